// File: rtl/vcf_pkg.sv
package vcf_pkg;

  // Frame geometry limits
  localparam int MAX_KERNEL   = 5;
  localparam int MAX_IN_SIDE  = 32;
  localparam int MAX_OUT_SIDE = 28;
  localparam int WSTORE_DEPTH = MAX_KERNEL * MAX_KERNEL;

  // Field widths
  localparam int PIX_W   = 8;
  localparam int COORD_W = 5;
  localparam int WIDX_W  = 5;
  localparam int SHIFT_W = 4;
  localparam int KSIZE_W = 3;
  localparam int OSIZE_W = 5;

  // Internal widths
  localparam int COL_W  = $clog2(MAX_IN_SIDE);
  localparam int SIDE_W = $clog2(MAX_IN_SIDE + 1);
  localparam int BANK_W = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
  localparam int PROD_W = 2 * PIX_W;
  localparam int ROW_W  = PROD_W + $clog2(MAX_KERNEL + 1);
  localparam int SUM_W  = ROW_W + $clog2(MAX_KERNEL + 1);

  // APB register file
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 4;
  localparam int REG_IDX_W  = APB_ADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_SHIFT = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_KSIZE = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_OSIZE = 2'd2;

  localparam logic FUNC_WEIGHT = 1'b0;
  localparam logic FUNC_PIXEL  = 1'b1;

  typedef logic signed [PIX_W-1:0] pix_t;
  typedef logic [BANK_W-1:0] bank_t;

  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               last;
  } coord_t;

  // Pixel entering the window stage
  typedef struct packed {
    logic   valid;
    logic   emit;
    pix_t   pix;
    coord_t coord;
  } win_in_t;

  // Status back from the datapath
  typedef struct packed {
    logic take;
    logic busy;
  } mac_stat_t;

endpackage

// File: rtl/vcf_in_if.sv
interface vcf_in_if;
  logic                          valid;
  logic                          ready;
  logic                          func;
  logic [vcf_pkg::WIDX_W-1:0]    weight_index;
  logic signed [vcf_pkg::PIX_W-1:0] data_value;

  modport source (output valid, func, weight_index, data_value, input ready);
  modport sink (input valid, func, weight_index, data_value, output ready);
endinterface

// File: rtl/vcf_out_if.sv
interface vcf_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [vcf_pkg::PIX_W-1:0] result_value;
  logic [vcf_pkg::COORD_W-1:0]      out_row;
  logic [vcf_pkg::COORD_W-1:0]      out_col;
  logic                             last;

  modport source (output valid, result_value, out_row, out_col, last, input ready);
  modport sink (input valid, result_value, out_row, out_col, last, output ready);
endinterface

// File: rtl/vcf_line_buf.sv
module vcf_line_buf (
  input  logic                        clk,
  input  logic                        wr_en,
  input  vcf_pkg::bank_t              wr_bank,
  input  logic [vcf_pkg::COL_W-1:0]   wr_col,
  input  vcf_pkg::pix_t               wr_data,
  output vcf_pkg::pix_t               rows [vcf_pkg::MAX_KERNEL]
);

  vcf_pkg::pix_t  rd_r [vcf_pkg::MAX_KERNEL];
  vcf_pkg::bank_t bank_r;

  // Bank holding the row d rows above the bank of the current row
  function automatic vcf_pkg::bank_t bank_back(vcf_pkg::bank_t b, int d);
    int t;
    t = int'(b) - d;
    if (t < 0) begin
      t = t + vcf_pkg::MAX_KERNEL;
    end
    return vcf_pkg::bank_t'(t);
  endfunction

  for (genvar b = 0; b < vcf_pkg::MAX_KERNEL; b++) begin : g_bank
    vcf_pkg::pix_t mem [vcf_pkg::MAX_IN_SIDE];

    always_ff @(posedge clk) begin
      if (wr_en && (int'(wr_bank) == b)) begin
        mem[wr_col] <= wr_data;
      end
      if (wr_en) begin
        rd_r[b] <= mem[wr_col];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      bank_r <= wr_bank;
    end
  end

  // rows[d] is the pixel d rows above the current one; rows[0] is the
  // current row's stale entry and is never used.
  always_comb begin
    for (int d = 0; d < vcf_pkg::MAX_KERNEL; d++) begin
      rows[d] = rd_r[bank_back(bank_r, d)];
    end
  end

endmodule

// File: rtl/vcf_mac.sv
module vcf_mac (
  input  logic                          clk,
  input  logic                          rst_n,
  input  vcf_pkg::win_in_t              win_in,
  input  vcf_pkg::pix_t                 rows [vcf_pkg::MAX_KERNEL],
  input  vcf_pkg::pix_t                 weights [vcf_pkg::WSTORE_DEPTH],
  input  logic [vcf_pkg::KSIZE_W-1:0]   ksize,
  input  logic [vcf_pkg::SHIFT_W-1:0]   shift_amt,
  output vcf_pkg::mac_stat_t            stat,
  output logic                          out_valid,
  input  logic                          out_ready,
  output vcf_pkg::pix_t                 out_result,
  output vcf_pkg::coord_t               out_coord
);

  localparam int K = vcf_pkg::MAX_KERNEL;

  typedef logic signed [vcf_pkg::PROD_W-1:0] prod_t;
  typedef logic signed [vcf_pkg::ROW_W-1:0]  rsum_t;
  typedef logic signed [vcf_pkg::SUM_W-1:0]  tsum_t;

  // Window: win_r[d][j] is the pixel d rows up and j columns left
  vcf_pkg::pix_t   win_r [K][K];
  vcf_pkg::pix_t   tw [K][K];
  prod_t           prod_r [K][K];
  prod_t           prod_nxt [K][K];
  rsum_t           rsum_r [K];
  rsum_t           rsum_nxt [K];
  tsum_t           total;
  tsum_t           shifted;

  logic            s2_v_r, s3_v_r, s4_v_r, out_v_r;
  vcf_pkg::coord_t s2_coord_r, s3_coord_r, s4_coord_r, out_coord_r;
  vcf_pkg::pix_t   out_result_r;
  logic            rdy2, rdy3, rdy4, rdy_out;
  logic            shift_in;

  // Weight index for tap (d, j) at kernel side kk; taps outside the kernel
  // get index zero.
  function automatic int tap_index(int kk, int d, int j);
    if (d < kk && j < kk) begin
      return (kk - 1 - d) * kk + (kk - 1 - j);
    end
    return 0;
  endfunction

  // Ready chain, back to front
  assign rdy_out  = !out_v_r || out_ready;
  assign rdy4     = !s4_v_r || rdy_out;
  assign rdy3     = !s3_v_r || rdy4;
  assign rdy2     = !s2_v_r || rdy3;
  assign shift_in = win_in.valid && rdy2;

  assign stat.take = rdy2;
  assign stat.busy = s2_v_r;

  // Tap weights: a static select by kernel side
  always_comb begin
    for (int d = 0; d < K; d++) begin
      for (int j = 0; j < K; j++) begin
        tw[d][j] = '0;
        for (int kk = 1; kk <= K; kk++) begin
          if ((int'(ksize) == kk) && (d < kk) && (j < kk)) begin
            tw[d][j] = weights[tap_index(kk, d, j)];
          end
        end
      end
    end
  end

  // Taps outside the kernel read zero, so stale or never-written window
  // entries never reach the sum.
  always_comb begin
    for (int d = 0; d < K; d++) begin
      for (int j = 0; j < K; j++) begin
        if ((d < int'(ksize)) && (j < int'(ksize))) begin
          prod_nxt[d][j] = prod_t'(win_r[d][j]) * prod_t'(tw[d][j]);
        end else begin
          prod_nxt[d][j] = '0;
        end
      end
    end
  end

  always_comb begin
    for (int d = 0; d < K; d++) begin
      rsum_nxt[d] = '0;
      for (int j = 0; j < K; j++) begin
        rsum_nxt[d] = rsum_nxt[d] + rsum_t'(prod_r[d][j]);
      end
    end
  end

  always_comb begin
    total = '0;
    for (int d = 0; d < K; d++) begin
      total = total + tsum_t'(rsum_r[d]);
    end
    shifted = total >>> shift_amt;
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (rdy2) begin
        s2_v_r <= win_in.valid && win_in.emit;
      end
      if (rdy3) begin
        s3_v_r <= s2_v_r;
      end
      if (rdy4) begin
        s4_v_r <= s3_v_r;
      end
      if (rdy_out) begin
        out_v_r <= s4_v_r;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (shift_in) begin
      for (int d = 0; d < K; d++) begin
        for (int j = K - 1; j > 0; j--) begin
          win_r[d][j] <= win_r[d][j-1];
        end
        win_r[d][0] <= (d == 0) ? win_in.pix : rows[d];
      end
      s2_coord_r <= win_in.coord;
    end
    if (s2_v_r && rdy3) begin
      prod_r     <= prod_nxt;
      s3_coord_r <= s2_coord_r;
    end
    if (s3_v_r && rdy4) begin
      rsum_r     <= rsum_nxt;
      s4_coord_r <= s3_coord_r;
    end
    if (s4_v_r && rdy_out) begin
      out_result_r <= shifted[vcf_pkg::PIX_W-1:0];
      out_coord_r  <= s4_coord_r;
    end
  end

  assign out_valid  = out_v_r;
  assign out_result = out_result_r;
  assign out_coord  = out_coord_r;

endmodule

// File: rtl/valid_conv2d_fixed_point.sv
// Channel  Ports                                                 Dir     Item
// -------  ----------------------------------------------------  ------  ---------------
// in_ch    valid, ready, func, weight_index, data_value          sink    weight or pixel
// out_ch   valid, ready, result_value, out_row, out_col, last    source  window result
// APB cfg  psel, penable, pwrite, paddr, pwdata, prdata, pready  slave   shift, sizes
//
// One item per cycle sustained while out_ch keeps up and no weight load waits on pixels.
// A result passes registered steps in order: line-buffer read, window shift, multiply,
// row sums, total plus shift. A weight load waits until no pixel sits ahead of the
// multiplier stage, so a new weight never hits an older window.
// rst_n (synchronous) clears frame position and pipeline valids; weight and line stores
// are not reset. A stall on out_ch fills pipeline bubbles before in_ch stops taking pixels.
module valid_conv2d_fixed_point (
  input  logic                               clk,
  input  logic                               rst_n,
  vcf_in_if.sink                             in_ch,
  vcf_out_if.source                          out_ch,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [vcf_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [vcf_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [vcf_pkg::APB_DATA_W-1:0]     prdata,
  output logic                               pready
);

  // Config registers
  logic [vcf_pkg::SHIFT_W-1:0] shift_r;
  logic [vcf_pkg::KSIZE_W-1:0] ksize_r;
  logic [vcf_pkg::OSIZE_W-1:0] osize_r;

  // Frame position of the next pixel; bank_r tracks row mod MAX_KERNEL
  logic [vcf_pkg::COL_W-1:0]   row_r, col_r;
  vcf_pkg::bank_t              bank_r;
  logic [vcf_pkg::COL_W-1:0]   row_nxt, col_nxt;
  vcf_pkg::bank_t              bank_nxt;

  vcf_pkg::pix_t               wstore_r [vcf_pkg::WSTORE_DEPTH];

  // Pixel stage in front of the window
  logic                        s1_v_r;
  logic                        s1_emit_r;
  vcf_pkg::pix_t               s1_pix_r;
  vcf_pkg::coord_t             s1_coord_r;

  logic [vcf_pkg::KSIZE_W-1:0] k_eff;
  logic [vcf_pkg::OSIZE_W-1:0] o_eff;
  logic [vcf_pkg::SIDE_W-1:0]  side;
  logic [vcf_pkg::SIDE_W-1:0]  k_w, o_w, cap_w;

  // Position of this pixel after the out-of-frame fixup
  logic [vcf_pkg::COL_W-1:0]   r_cur, c_cur;
  vcf_pkg::bank_t              b_cur;
  logic [vcf_pkg::SIDE_W-1:0]  r_inc, c_inc;
  logic                        emit;
  logic [vcf_pkg::SIDE_W-1:0]  r0, c0;
  vcf_pkg::coord_t             coord;

  logic                        cfg_wr, cfg_hit;
  logic [vcf_pkg::REG_IDX_W-1:0] reg_idx;
  logic                        pix_ready, wgt_ready;
  logic                        pix_acc, wgt_acc;

  vcf_pkg::win_in_t            win_in;
  vcf_pkg::mac_stat_t          stat;
  vcf_pkg::pix_t               rows [vcf_pkg::MAX_KERNEL];
  vcf_pkg::pix_t               res;
  vcf_pkg::coord_t             res_coord;

  // ---------------- APB ----------------
  assign pready  = 1'b1;
  assign reg_idx = paddr[vcf_pkg::APB_ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_hit = cfg_wr && ((reg_idx == vcf_pkg::REG_SHIFT) ||
                              (reg_idx == vcf_pkg::REG_KSIZE) ||
                              (reg_idx == vcf_pkg::REG_OSIZE));

  always_comb begin
    case (reg_idx)
      vcf_pkg::REG_SHIFT: prdata = vcf_pkg::APB_DATA_W'(shift_r);
      vcf_pkg::REG_KSIZE: prdata = vcf_pkg::APB_DATA_W'(ksize_r);
      vcf_pkg::REG_OSIZE: prdata = vcf_pkg::APB_DATA_W'(osize_r);
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r <= '0;
      ksize_r <= vcf_pkg::KSIZE_W'(vcf_pkg::MAX_KERNEL);
      osize_r <= vcf_pkg::OSIZE_W'(vcf_pkg::MAX_OUT_SIDE);
    end else if (cfg_wr) begin
      case (reg_idx)
        vcf_pkg::REG_SHIFT: shift_r <= pwdata[vcf_pkg::SHIFT_W-1:0];
        vcf_pkg::REG_KSIZE: ksize_r <= pwdata[vcf_pkg::KSIZE_W-1:0];
        vcf_pkg::REG_OSIZE: osize_r <= pwdata[vcf_pkg::OSIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- Effective geometry ----------------
  // Zero means one; clamp to the store sizes.
  always_comb begin
    k_eff = ksize_r;
    if (k_eff == '0) begin
      k_eff = vcf_pkg::KSIZE_W'(1);
    end
    if (int'(k_eff) > vcf_pkg::MAX_KERNEL) begin
      k_eff = vcf_pkg::KSIZE_W'(vcf_pkg::MAX_KERNEL);
    end
    k_w   = vcf_pkg::SIDE_W'(k_eff);
    cap_w = vcf_pkg::SIDE_W'(vcf_pkg::MAX_IN_SIDE + 1) - k_w;

    o_eff = osize_r;
    if (o_eff == '0) begin
      o_eff = vcf_pkg::OSIZE_W'(1);
    end
    if (int'(o_eff) > vcf_pkg::MAX_OUT_SIDE) begin
      o_eff = vcf_pkg::OSIZE_W'(vcf_pkg::MAX_OUT_SIDE);
    end
    o_w = vcf_pkg::SIDE_W'(o_eff);
    if (o_w > cap_w) begin
      o_w = cap_w;
    end
    side = o_w + k_w - vcf_pkg::SIDE_W'(1);
  end

  // ---------------- Input handshake ----------------
  // Pixels flow whenever the window stage has room; a weight waits until no
  // pixel is ahead of the multiplier.
  assign pix_ready   = !s1_v_r || stat.take;
  assign wgt_ready   = !s1_v_r && !stat.busy;
  assign in_ch.ready = (in_ch.func == vcf_pkg::FUNC_WEIGHT) ? wgt_ready : pix_ready;
  assign pix_acc     = in_ch.valid && pix_ready && (in_ch.func == vcf_pkg::FUNC_PIXEL);
  assign wgt_acc     = in_ch.valid && wgt_ready && (in_ch.func == vcf_pkg::FUNC_WEIGHT);

  // ---------------- Frame position ----------------
  always_comb begin
    r_cur = row_r;
    c_cur = col_r;
    b_cur = bank_r;
    // Position left over from a larger frame restarts at the origin
    if ((vcf_pkg::SIDE_W'(row_r) >= side) || (vcf_pkg::SIDE_W'(col_r) >= side)) begin
      r_cur = '0;
      c_cur = '0;
      b_cur = '0;
    end
    r_inc = vcf_pkg::SIDE_W'(r_cur) + vcf_pkg::SIDE_W'(1);
    c_inc = vcf_pkg::SIDE_W'(c_cur) + vcf_pkg::SIDE_W'(1);

    emit = (r_inc >= k_w) && (c_inc >= k_w);
    r0   = r_inc - k_w;
    c0   = c_inc - k_w;
    coord.row  = r0[vcf_pkg::COORD_W-1:0];
    coord.col  = c0[vcf_pkg::COORD_W-1:0];
    coord.last = (r0 == o_w - vcf_pkg::SIDE_W'(1)) && (c0 == o_w - vcf_pkg::SIDE_W'(1));

    // Raster advance
    row_nxt  = r_cur;
    bank_nxt = b_cur;
    if (c_inc >= side) begin
      col_nxt = '0;
      if (r_inc >= side) begin
        row_nxt  = '0;
        bank_nxt = '0;
      end else begin
        row_nxt  = r_inc[vcf_pkg::COL_W-1:0];
        bank_nxt = (int'(b_cur) == vcf_pkg::MAX_KERNEL - 1) ? '0
                                                            : b_cur + vcf_pkg::bank_t'(1);
      end
    end else begin
      col_nxt = c_inc[vcf_pkg::COL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r  <= '0;
      col_r  <= '0;
      bank_r <= '0;
    end else if (cfg_hit || wgt_acc) begin
      row_r  <= '0;
      col_r  <= '0;
      bank_r <= '0;
    end else if (pix_acc) begin
      row_r  <= row_nxt;
      col_r  <= col_nxt;
      bank_r <= bank_nxt;
    end
  end

  // ---------------- Weight store ----------------
  always_ff @(posedge clk) begin
    if (wgt_acc && (int'(in_ch.weight_index) < vcf_pkg::WSTORE_DEPTH)) begin
      wstore_r[in_ch.weight_index] <= in_ch.data_value;
    end
  end

  // ---------------- Pixel stage ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (pix_ready) begin
      s1_v_r <= pix_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_acc) begin
      s1_pix_r   <= in_ch.data_value;
      s1_emit_r  <= emit;
      s1_coord_r <= coord;
    end
  end

  assign win_in.valid = s1_v_r;
  assign win_in.emit  = s1_emit_r;
  assign win_in.pix   = s1_pix_r;
  assign win_in.coord = s1_coord_r;

  // Line buffer: written and read at the pixel's column as it is accepted,
  // read data lines up with the pixel stage.
  vcf_line_buf u_line_buf (
    .clk     (clk),
    .wr_en   (pix_acc),
    .wr_bank (b_cur),
    .wr_col  (c_cur),
    .wr_data (in_ch.data_value),
    .rows    (rows)
  );

  vcf_mac u_mac (
    .clk        (clk),
    .rst_n      (rst_n),
    .win_in     (win_in),
    .rows       (rows),
    .weights    (wstore_r),
    .ksize      (k_eff),
    .shift_amt  (shift_r),
    .stat       (stat),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_result (res),
    .out_coord  (res_coord)
  );

  assign out_ch.result_value = res;
  assign out_ch.out_row      = res_coord.row;
  assign out_ch.out_col      = res_coord.col;
  assign out_ch.last         = res_coord.last;

endmodule

// File: tb/valid_conv2d_fixed_point_checker.sv
`timescale 1ns / 100ps

module valid_conv2d_fixed_point_checker
  import vcf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  vcf_in_if                     in_ch,
  vcf_out_if                    out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output int                    n_pending,
  output int                    n_errors
);

  localparam int LINE_DEPTH = MAX_KERNEL * MAX_IN_SIDE;

  typedef struct packed {
    pix_t               value;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               last;
  } window_sum_t;

  logic [SHIFT_W-1:0] shift_q;
  logic [KSIZE_W-1:0] ksize_q;
  logic [OSIZE_W-1:0] osize_q;
  pix_t               weights [WSTORE_DEPTH];
  pix_t               lines [LINE_DEPTH];
  int unsigned        cur_row;
  int unsigned        cur_col;
  window_sum_t        expected_sums [$];

  // Store the pixel, queue the window sum it completes (if any), advance raster position.
  task automatic take_pixel(input pix_t px);
    int unsigned k, o, side, r, c, r0, c0;
    int          acc;
    window_sum_t res;
    k = (ksize_q == 0) ? 1 : ((ksize_q > MAX_KERNEL) ? MAX_KERNEL : ksize_q);
    o = (osize_q == 0) ? 1 : osize_q;
    if (o > MAX_OUT_SIDE) o = MAX_OUT_SIDE;
    if (o > MAX_IN_SIDE - k + 1) o = MAX_IN_SIDE - k + 1;
    side = o + k - 1;
    r = cur_row;
    c = cur_col;
    if (r >= side || c >= side) begin
      r = 0;
      c = 0;
    end
    lines[(r % MAX_KERNEL) * MAX_IN_SIDE + c] = px;
    if (r + 1 >= k && c + 1 >= k) begin
      r0  = r + 1 - k;
      c0  = c + 1 - k;
      acc = 0;
      for (int i = 0; i < k; i++) begin
        for (int j = 0; j < k; j++) begin
          acc += int'(lines[((r0 + i) % MAX_KERNEL) * MAX_IN_SIDE + c0 + j]) *
                 int'(weights[i * k + j]);
        end
      end
      res.value = pix_t'(acc >>> shift_q);
      res.row   = COORD_W'(r0);
      res.col   = COORD_W'(c0);
      res.last  = (r0 == o - 1) && (c0 == o - 1);
      expected_sums.push_back(res);
    end
    if (c + 1 >= side) begin
      c = 0;
      r = (r + 1 >= side) ? 0 : r + 1;
    end else begin
      c = c + 1;
    end
    cur_row = r;
    cur_col = c;
  endtask

  task automatic check_field(input string what, input logic signed [31:0] want, got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
      n_errors++;
    end
  endtask

  always @(posedge clk) begin
    window_sum_t want;
    if (!rst_n) begin
      shift_q = '0;
      ksize_q = KSIZE_W'(5);
      osize_q = OSIZE_W'(28);
      cur_row = 0;
      cur_col = 0;
      foreach (weights[i]) weights[i] = '0;
      foreach (lines[i]) lines[i] = '0;
      expected_sums.delete();
    end else begin
      // register writes restart the frame
      if (psel && penable && pwrite && pready) begin
        case (paddr[APB_ADDR_W-1:2])
          REG_SHIFT: shift_q = pwdata[SHIFT_W-1:0];
          REG_KSIZE: ksize_q = pwdata[KSIZE_W-1:0];
          REG_OSIZE: osize_q = pwdata[OSIZE_W-1:0];
          default: ;
        endcase
        if (paddr[APB_ADDR_W-1:2] inside {REG_SHIFT, REG_KSIZE, REG_OSIZE}) begin
          cur_row = 0;
          cur_col = 0;
        end
      end

      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.func == FUNC_WEIGHT) begin
          if (in_ch.weight_index < WSTORE_DEPTH) weights[in_ch.weight_index] = in_ch.data_value;
          cur_row = 0;
          cur_col = 0;
        end else begin
          take_pixel(in_ch.data_value);
        end
      end

      if (out_ch.valid && out_ch.ready) begin
        if (expected_sums.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual value %0d row %0d",
                   $time, out_ch.result_value, out_ch.out_row);
          $display("%0t:   actual col %0d last %0b", $time, out_ch.out_col, out_ch.last);
          n_errors++;
        end else begin
          want = expected_sums.pop_front();
          check_field("result_value", want.value, out_ch.result_value);
          check_field("out_row", want.row, out_ch.out_row);
          check_field("out_col", want.col, out_ch.out_col);
          check_field("last", want.last, out_ch.last);
        end
      end
    end
    n_pending <= expected_sums.size();
  end

endmodule

// File: tb/valid_conv2d_fixed_point_tb.sv
`timescale 1ns / 100ps

module valid_conv2d_fixed_point_tb;
  import vcf_pkg::*;

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  vcf_in_if  in_ch ();
  vcf_out_if out_ch ();

  int   n_pending;      // window sums predicted but not yet seen
  int   n_errors;
  int   items_sent;     // accepted input items
  int   weights_ready;  // leading weight slots known to be written
  logic calm;           // no random idling on either side for this phase
  logic quiet_tail;     // end of run: no idling at all
  logic long_hold_req;  // ask the receiver for one long back-pressure stretch

  valid_conv2d_fixed_point i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  valid_conv2d_fixed_point_checker i_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .pready    (pready),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .n_pending (n_pending),
    .n_errors  (n_errors)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop. Worst case is roughly 1300 items, each with a longest input gap, a longest
  // result stall and the pipeline, well under a third of this.
  initial begin
    #3_000_000;
    $display("valid_conv2d_fixed_point regression: fail");
    $finish;
  end

  // Result side back-pressure: random stall bursts, plus one long hold on request
  // so the pipeline fills and the block has to stop taking pixels.
  initial begin
    bit held;
    held = 1'b0;
    out_ch.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (long_hold_req && !held) begin
        held = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (100) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else if (!calm && !quiet_tail && $urandom_range(0, 9) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Byte with a bias toward the two extremes.
  function automatic pix_t rand_byte();
    case ($urandom_range(0, 15))
      0:       return -8'sd128;
      1:       return 8'sd127;
      default: return pix_t'($urandom);
    endcase
  endfunction

  // Offer one item and hold it until taken; then maybe leave a gap.
  // valid stays high across back-to-back items.
  task automatic push_item(input logic f, input logic [WIDX_W-1:0] idx, input pix_t v);
    in_ch.func         <= f;
    in_ch.weight_index <= idx;
    in_ch.data_value   <= v;
    in_ch.valid        <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
    if (!calm && !quiet_tail && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  // APB write: setup, access, then idle with psel low, so back-to-back writes
  // never put two assignments on psel in one step.
  task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input int unsigned value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Registers change only with the block idle: every predicted sum out, then
  // enough cycles for trailing pixels / a held weight load to leave the pipe.
  task automatic wait_drain();
    do @(posedge clk); while (n_pending != 0);
    repeat (12) @(posedge clk);
  endtask

  task automatic load_weights(input int unsigned count);
    for (int i = 0; i < count; i++) push_item(FUNC_WEIGHT, WIDX_W'(i), rand_byte());
    if (count > weights_ready) weights_ready = count;
  endtask

  initial begin
    pix_t                frame_a [9];
    logic [SHIFT_W-1:0]  sh;
    logic [KSIZE_W-1:0]  ks;
    logic [OSIZE_W-1:0]  os;
    logic [2:0]          wmask;
    int unsigned         k_eff, o_eff, side, npix;
    int                  phase;

    frame_a = '{8'sd127, -8'sd128, -8'sd128, 8'sd127, 8'sd0, 8'sd1, -8'sd1, 8'sd127, -8'sd128};

    rst_n              <= 1'b0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.func         <= FUNC_PIXEL;
    in_ch.weight_index <= '0;
    in_ch.data_value   <= '0;
    calm               <= 1'b0;
    quiet_tail         <= 1'b0;
    long_hold_req      <= 1'b0;
    items_sent    = 0;
    weights_ready = 0;
    ks = KSIZE_W'(5);
    os = OSIZE_W'(28);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- Directed: 2x2 kernel over a 3x3 frame ----
    reg_write(REG_SHIFT, 0);
    reg_write(REG_KSIZE, 2);
    reg_write(REG_OSIZE, 2);
    ks = KSIZE_W'(2);
    os = OSIZE_W'(2);
    // extreme weights
    push_item(FUNC_WEIGHT, 0, -8'sd128);
    push_item(FUNC_WEIGHT, 1, 8'sd127);
    push_item(FUNC_WEIGHT, 2, -8'sd1);
    push_item(FUNC_WEIGHT, 3, 8'sd1);
    weights_ready = 4;
    // indexes past the store: nothing written, frame restarts
    push_item(FUNC_WEIGHT, 31, 8'sh5a);
    push_item(FUNC_WEIGHT, 25, 8'sd0);
    // full frame, extreme pixels; sums wrap at shift 0
    foreach (frame_a[i]) push_item(FUNC_PIXEL, $urandom_range(0, 31), frame_a[i]);
    // weight load mid-frame restarts at row 0, column 0
    push_item(FUNC_PIXEL, 0, 8'sd127);
    push_item(FUNC_PIXEL, 31, -8'sd128);
    push_item(FUNC_WEIGHT, 3, 8'sd127);
    foreach (frame_a[i]) push_item(FUNC_PIXEL, $urandom_range(0, 31), frame_a[i]);
    in_ch.valid <= 1'b0;

    // ---- Phases: fixed extreme settings first, then random ones ----
    phase = 0;
    while (items_sent < 1050) begin
      wait_drain();
      wmask = 3'b111;
      case (phase)
        0: begin sh = 15; ks = 5; os = 31; end  // out side saturates, 32-pixel rows
        1: begin sh = 0;  ks = 1; os = 1;  end  // one result per pixel, used for pressure
        2: begin sh = 7;  ks = 0; os = 0;  end  // zero sizes read as one
        3: begin sh = 3;  ks = 7; os = 5;  end  // kernel above max saturates
        4: begin sh = 15; ks = 1; os = 28; end
        5: begin sh = 9;  ks = 4; os = 30; end
        default: begin
          wmask = 3'($urandom_range(1, 7));
          sh    = ($urandom_range(0, 4) == 0) ? SHIFT_W'($urandom_range(0, 1) * 15)
                                              : SHIFT_W'($urandom_range(0, 15));
          if (wmask[1]) ks = KSIZE_W'($urandom_range(0, 7));
          if (wmask[2]) begin
            os = ($urandom_range(0, 9) == 0) ? OSIZE_W'($urandom_range(26, 31))
                                             : OSIZE_W'($urandom_range(0, 6));
          end
        end
      endcase
      // any subset of writes restarts the frame; unwritten registers keep
      // their previous value, which the local copies ks/os track
      if (wmask[0]) reg_write(REG_SHIFT, sh);
      if (wmask[1]) reg_write(REG_KSIZE, ks);
      if (wmask[2]) reg_write(REG_OSIZE, os);

      // effective geometry, only to shape the stimulus
      k_eff = (ks == 0) ? 1 : ((ks > MAX_KERNEL) ? MAX_KERNEL : ks);
      o_eff = (os == 0) ? 1 : ((os > MAX_OUT_SIDE) ? MAX_OUT_SIDE : os);
      if (o_eff > MAX_IN_SIDE - k_eff + 1) o_eff = MAX_IN_SIDE - k_eff + 1;
      side = o_eff + k_eff - 1;

      calm <= (phase == 1) || ($urandom_range(0, 4) == 0);

      // every weight the kernel reads must be written before the first window
      if (k_eff * k_eff > weights_ready || $urandom_range(0, 1) == 1)
        load_weights(k_eff * k_eff);

      if (phase == 1) begin
        npix = 200;
        long_hold_req <= 1'b1;
      end else if (side > 12) begin
        // large frames: a few rows only
        npix = $urandom_range(3 * side, 6 * side);
      end else begin
        npix = $urandom_range(1, 3) * side * side;
        if ($urandom_range(0, 2) == 0) npix += $urandom_range(0, side * side - 1);
      end

      for (int n = 0; n < npix && items_sent < 1050; n++) begin
        // stray weight loads break the frame and hit out-of-store indexes
        if ($urandom_range(0, 39) == 0)
          push_item(FUNC_WEIGHT, WIDX_W'($urandom_range(0, 31)), rand_byte());
        push_item(FUNC_PIXEL, WIDX_W'($urandom_range(0, 31)), rand_byte());
        if (items_sent >= 900) quiet_tail <= 1'b1;
      end
      in_ch.valid <= 1'b0;
      phase++;
    end

    // ---- Drain and verdict ----
    for (int t = 0; t < 2000 && n_pending != 0; t++) @(posedge clk);
    repeat (20) @(posedge clk);
    if (n_errors == 0 && n_pending == 0) begin
      $display("valid_conv2d_fixed_point regression: pass");
    end else begin
      $display("valid_conv2d_fixed_point regression: fail");
    end
    $finish;
  end

endmodule
